### rtl/mbw_pkg.sv
`default_nettype none

package mbw_pkg;

    // field widths
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned SEQ_W    = 64;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam int unsigned US_PER_MS = 1000;

    // stall threshold in microseconds: elapsed ms > limit <=> elapsed_us >= (limit + 1) * 1000
    localparam int unsigned THR_W = 26;

    localparam logic [LIMIT_W-1:0] WARN_LIMIT_RST     = 16'd200;
    localparam logic [LIMIT_W-1:0] SHUTDOWN_LIMIT_RST = 16'd500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd2;

    typedef enum logic [1:0] {
        SEV_OK    = 2'd0,
        SEV_WARN  = 2'd1,
        SEV_FAULT = 2'd2
    } sev_t;

    typedef enum logic {
        CAUSE_NONE    = 1'b0,
        CAUSE_TIMEOUT = 1'b1
    } cause_t;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_ZERO_TORQUE = 2'd1,
        ACT_DISABLE     = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_RUNNING = 2'd1,
        REQ_FAULT   = 2'd2
    } req_t;

    // settings handed from the register block to the watchdog
    typedef struct packed {
        logic [THR_W-1:0] warn_thr_us;
        logic [THR_W-1:0] shut_thr_us;
        logic             seq_load;
        logic [SEQ_W-1:0] seq_value;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic   command_taken;
        act_t   action;
        req_t   request;
        sev_t   severity;
        cause_t cause;
    } res_t;

    function automatic logic [THR_W-1:0] limit_to_thr(input logic [LIMIT_W-1:0] limit_ms);
        logic [31:0] prod;
        prod = (32'(limit_ms) + 32'd1) * 32'(US_PER_MS);
        return prod[THR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/mailbox_stall_watchdog.sv
`default_nettype none

// channel   | direction | handshake          | word
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_valid / s_ready  | now_us, seq_start, seq_end
// m_        | out       | m_valid / m_ready  | command_taken, safety_action,
//           |           |                    | state_request, severity, fault_cause
// cfg_      | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// one word per cycle sustained while m_ready holds high; m_valid rises once the word has
// passed the input register and the watchdog decision lands in the result register
// watchdog state commits as a word enters the result register, no bubble between words
// aresetn is synchronous and active low; register defaults and watchdog state restored
// a stalled m_ side holds its word; s_ready stays high while the input register is
// empty or its word moves on this cycle; two words fill the block

module mailbox_stall_watchdog
    import mbw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output wire logic                  s_ready,
    input  wire logic [TIME_W-1:0]     s_now_us,
    input  wire logic [SEQ_W-1:0]      s_seq_start,
    input  wire logic [SEQ_W-1:0]      s_seq_end,

    output wire logic                  m_valid,
    input  wire logic                  m_ready,
    output wire logic                  m_command_taken,
    output wire logic [1:0]            m_safety_action,
    output wire logic [1:0]            m_state_request,
    output wire logic [1:0]            m_severity,
    output wire logic                  m_fault_cause,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [TIME_W-1:0] in_now_reg;
    logic [SEQ_W-1:0]  in_begin_reg;
    logic [SEQ_W-1:0]  in_end_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    logic              s_fire;
    logic              advance;
    cfg_t              cfg;
    res_t              res;

    // the input word moves on whenever the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    mbw_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // decision logic and watchdog state, committed on advance
    mbw_watch u_watch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fire      (advance),
        .now_us    (in_now_reg),
        .seq_start (in_begin_reg),
        .seq_end   (in_end_reg),
        .res       (res)
    );

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_now_reg   <= s_now_us;
            in_begin_reg <= s_seq_start;
            in_end_reg   <= s_seq_end;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_command_taken = out_res_reg.command_taken;
    assign m_safety_action = out_res_reg.action;
    assign m_state_request = out_res_reg.request;
    assign m_severity      = out_res_reg.severity;
    assign m_fault_cause   = out_res_reg.cause;

endmodule

`default_nettype wire

### rtl/mbw_cfg_regs.sv
`default_nettype none

module mbw_cfg_regs
    import mbw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    logic [THR_W-1:0] warn_thr_reg;
    logic [THR_W-1:0] shut_thr_reg;
    logic [THR_W-1:0] wr_thr;

    // limits are kept as microsecond thresholds, scaled once on write
    assign wr_thr = limit_to_thr(cfg_wdata[LIMIT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_thr_reg <= limit_to_thr(WARN_LIMIT_RST);
            shut_thr_reg <= limit_to_thr(SHUTDOWN_LIMIT_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WARN_LIMIT:     warn_thr_reg <= wr_thr;
                CFG_SHUTDOWN_LIMIT: shut_thr_reg <= wr_thr;
                default: ;
            endcase
        end
    end

    assign cfg.warn_thr_us = warn_thr_reg;
    assign cfg.shut_thr_us = shut_thr_reg;
    assign cfg.seq_load    = cfg_we && (cfg_index == CFG_START_SEQUENCE);
    assign cfg.seq_value   = cfg_wdata[SEQ_W-1:0];

endmodule

`default_nettype wire

### rtl/mbw_watch.sv
`default_nettype none

module mbw_watch
    import mbw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              fire,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire logic [SEQ_W-1:0]  seq_start,
    input  wire logic [SEQ_W-1:0]  seq_end,
    output res_t                   res
);

    logic [SEQ_W-1:0]  last_seq_reg, last_seq_next;
    logic [TIME_W-1:0] stall_start_reg, stall_start_next;
    logic              stall_running_reg, stall_running_next;
    logic              fault_latched_reg, fault_latched_next;
    sev_t              sev_reg, sev_next;
    cause_t            cause_reg, cause_next;

    logic              taken;
    logic              begin_eq_last;
    logic              last_nonzero;
    logic [TIME_W-1:0] elapsed_us;
    logic              over_shut;
    logic              over_warn;

    always_comb begin
        taken         = (seq_start == seq_end) && (seq_start != last_seq_reg);
        // after a take the last sequence is the begin itself
        begin_eq_last = taken || (seq_start == last_seq_reg);
        last_nonzero  = taken ? (seq_start != '0) : (last_seq_reg != '0);
        elapsed_us    = stall_running_reg ? (now_us - stall_start_reg) : '0;
        over_shut     = (elapsed_us[TIME_W-1:THR_W] != '0) ||
                        (elapsed_us[THR_W-1:0] >= cfg.shut_thr_us);
        over_warn     = (elapsed_us[TIME_W-1:THR_W] != '0) ||
                        (elapsed_us[THR_W-1:0] >= cfg.warn_thr_us);

        last_seq_next      = taken ? seq_start : last_seq_reg;
        stall_start_next   = stall_start_reg;
        stall_running_next = stall_running_reg;
        fault_latched_next = fault_latched_reg;
        sev_next           = sev_reg;
        cause_next         = cause_reg;

        res.command_taken = taken;
        res.action        = ACT_NONE;
        res.request       = (taken && (last_seq_reg == '0)) ? REQ_RUNNING : REQ_NONE;

        if (last_nonzero) begin
            if (begin_eq_last) begin
                if (!stall_running_reg) begin
                    stall_running_next = 1'b1;
                    stall_start_next   = now_us;
                end
                // shutdown checked first, so it wins over warn
                if (over_shut) begin
                    if (!fault_latched_reg) begin
                        fault_latched_next = 1'b1;
                        sev_next           = SEV_FAULT;
                        cause_next         = CAUSE_TIMEOUT;
                        res.request        = REQ_FAULT;
                        res.action         = ACT_DISABLE;
                    end
                end else if (over_warn) begin
                    if (sev_reg == SEV_OK) begin
                        sev_next   = SEV_WARN;
                        cause_next = CAUSE_TIMEOUT;
                        res.action = ACT_ZERO_TORQUE;
                    end
                end
            end else begin
                stall_running_next = 1'b0;
                stall_start_next   = '0;
                fault_latched_next = 1'b0;
                if (sev_reg == SEV_WARN && cause_reg == CAUSE_TIMEOUT) begin
                    sev_next   = SEV_OK;
                    cause_next = CAUSE_NONE;
                end
            end
        end

        res.severity = sev_next;
        res.cause    = cause_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg      <= '0;
            stall_start_reg   <= '0;
            stall_running_reg <= 1'b0;
            fault_latched_reg <= 1'b0;
            sev_reg           <= SEV_OK;
            cause_reg         <= CAUSE_NONE;
        end else if (cfg.seq_load) begin
            last_seq_reg <= cfg.seq_value;
        end else if (fire) begin
            last_seq_reg      <= last_seq_next;
            stall_start_reg   <= stall_start_next;
            stall_running_reg <= stall_running_next;
            fault_latched_reg <= fault_latched_next;
            sev_reg           <= sev_next;
            cause_reg         <= cause_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mbw_checker.sv
`default_nettype none

module mbw_checker
    import mbw_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_command_taken,
    input wire logic [1:0] m_safety_action,
    input wire logic [1:0] m_state_request,
    input wire logic [1:0] m_severity,
    input wire logic       m_fault_cause
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_command_taken) &&
            $stable(m_safety_action) && $stable(m_state_request) &&
            $stable(m_severity) && $stable(m_fault_cause)))
        else $error("result word changed while stalled");

    // a fault request always comes with disable and a timeout fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_state_request == REQ_FAULT) |->
            (m_safety_action == ACT_DISABLE && m_severity == SEV_FAULT &&
             m_fault_cause == CAUSE_TIMEOUT))
        else $error("fault request without disable or fault severity");

    // zero torque only when a timeout warning is raised
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_safety_action == ACT_ZERO_TORQUE) |->
            (m_severity == SEV_WARN && m_fault_cause == CAUSE_TIMEOUT &&
             m_state_request != REQ_FAULT))
        else $error("zero torque without timeout warning");

    // running request only with a taken command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_state_request == REQ_RUNNING) |-> m_command_taken)
        else $error("running request without a taken command");

    // fault severity only ever comes from a timeout
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_severity == SEV_FAULT) |-> (m_fault_cause == CAUSE_TIMEOUT))
        else $error("fault severity without timeout cause");

endmodule

bind mailbox_stall_watchdog mbw_checker u_mbw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_command_taken (m_command_taken),
    .m_safety_action (m_safety_action),
    .m_state_request (m_state_request),
    .m_severity      (m_severity),
    .m_fault_cause   (m_fault_cause)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mbw_pkg::*;

    // one mailbox snapshot as the block sees it on a tick
    typedef struct packed {
        logic [TIME_W-1:0] now_us;
        logic [SEQ_W-1:0]  seq_start;
        logic [SEQ_W-1:0]  seq_end;
    } tick_t;

    localparam logic [TIME_W-1:0] MICROS_PER_MS = 64'd1000;
    localparam logic [SEQ_W-1:0]  ALL_ONES      = {SEQ_W{1'b1}};

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid     = 1'b0;
    wire                   s_ready;
    logic [TIME_W-1:0]     s_now_us    = '0;
    logic [SEQ_W-1:0]      s_seq_start = '0;
    logic [SEQ_W-1:0]      s_seq_end   = '0;

    wire                   m_valid;
    logic                  m_ready = 1'b0;
    wire                   m_command_taken;
    wire [1:0]             m_safety_action;
    wire [1:0]             m_state_request;
    wire [1:0]             m_severity;
    wire                   m_fault_cause;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WARN_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    mailbox_stall_watchdog u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_us        (s_now_us),
        .s_seq_start     (s_seq_start),
        .s_seq_end       (s_seq_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command_taken (m_command_taken),
        .m_safety_action (m_safety_action),
        .m_state_request (m_state_request),
        .m_severity      (m_severity),
        .m_fault_cause   (m_fault_cause),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // watchdog mirror: settings and state as the block should hold them
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] warn_ms       = WARN_LIMIT_RST;
    logic [LIMIT_W-1:0] shut_ms       = SHUTDOWN_LIMIT_RST;
    logic [SEQ_W-1:0]   mb_last_seq   = '0;
    logic [TIME_W-1:0]  stall_from_us = '0;
    logic               stall_armed   = 1'b0;
    logic               fault_held    = 1'b0;
    sev_t               sev_now       = SEV_OK;
    cause_t             cause_now     = CAUSE_NONE;

    // works out the result word for one tick and moves the mirror on
    function automatic res_t judge_tick(input tick_t tk);
        res_t              r;
        logic [TIME_W-1:0] elapsed_ms;
        r.command_taken = 1'b0;
        r.action        = ACT_NONE;
        r.request       = REQ_NONE;
        // a settled snapshot with a new sequence is taken first
        if (tk.seq_start == tk.seq_end && tk.seq_start != mb_last_seq) begin
            if (mb_last_seq == '0)
                r.request = REQ_RUNNING;
            mb_last_seq     = tk.seq_start;
            r.command_taken = 1'b1;
        end
        // stall check runs against the sequence as updated above
        if (mb_last_seq != '0) begin
            if (tk.seq_start == mb_last_seq) begin
                if (!stall_armed) begin
                    stall_armed   = 1'b1;
                    stall_from_us = tk.now_us;
                end
                // wraps modulo 2^64, so time going backwards reads as a huge stall
                elapsed_ms = (tk.now_us - stall_from_us) / MICROS_PER_MS;
                if (elapsed_ms > TIME_W'(shut_ms)) begin
                    if (!fault_held) begin
                        fault_held = 1'b1;
                        sev_now    = SEV_FAULT;
                        cause_now  = CAUSE_TIMEOUT;
                        r.request  = REQ_FAULT;
                        r.action   = ACT_DISABLE;
                    end
                end else if (elapsed_ms > TIME_W'(warn_ms)) begin
                    if (sev_now < SEV_WARN) begin
                        sev_now   = SEV_WARN;
                        cause_now = CAUSE_TIMEOUT;
                        r.action  = ACT_ZERO_TORQUE;
                    end
                end
            end else begin
                // mailbox is moving again: timer and latch cleared, fault severity sticks
                stall_armed   = 1'b0;
                stall_from_us = '0;
                fault_held    = 1'b0;
                if (sev_now == SEV_WARN && cause_now == CAUSE_TIMEOUT) begin
                    sev_now   = SEV_OK;
                    cause_now = CAUSE_NONE;
                end
            end
        end
        r.severity = sev_now;
        r.cause    = cause_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // queues, counters and idling control
    // ------------------------------------------------------------------
    tick_t        ticks_to_send[$];
    res_t         due_words[$];
    int unsigned  ticks_made   = 0;
    int unsigned  mismatches   = 0;
    int unsigned  results_seen = 0;
    bit           calm         = 1'b0;   // set for the last stretch: no idling at all
    int unsigned  send_gap     = 0;
    int unsigned  hold_left    = 0;
    bit           long_hold_done = 1'b0;
    tick_t        next_tick;
    tick_t        seen_tick;
    res_t         want_word;

    // stimulus generator's view of the mailbox
    logic [TIME_W-1:0] gen_now = '0;
    logic [SEQ_W-1:0]  gen_seq = '0;

    task automatic flag(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want)
            flag($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued ticks, random gaps only between words
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // the slot is free: nothing offered or the current word goes now
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (ticks_to_send.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                send_gap <= $urandom_range(0, 8);
                s_valid  <= 1'b0;
            end else begin
                next_tick   = ticks_to_send.pop_front();
                s_valid     <= 1'b1;
                s_now_us    <= next_tick.now_us;
                s_seq_start <= next_tick.seq_start;
                s_seq_end   <= next_tick.seq_end;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off mid run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!long_hold_done && results_seen >= 350) begin
            // long enough for the block to fill and drop s_ready
            long_hold_done <= 1'b1;
            hold_left      <= 59;
            m_ready        <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            hold_left <= $urandom_range(0, 8);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every accepted tick, checks every result word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen_tick.now_us    = s_now_us;
                seen_tick.seq_start = s_seq_start;
                seen_tick.seq_end   = s_seq_end;
                due_words.push_back(judge_tick(seen_tick));
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (due_words.size() == 0) begin
                    flag("result word with nothing outstanding");
                end else begin
                    want_word = due_words.pop_front();
                    check_field("command_taken", {1'b0, m_command_taken},
                                {1'b0, want_word.command_taken});
                    check_field("safety_action", m_safety_action, want_word.action);
                    check_field("state_request", m_state_request, want_word.request);
                    check_field("severity", m_severity, want_word.severity);
                    check_field("fault_cause", {1'b0, m_fault_cause},
                                {1'b0, want_word.cause});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic [TIME_W-1:0] now_us,
                             input logic [SEQ_W-1:0] seq_b,
                             input logic [SEQ_W-1:0] seq_e);
        tick_t tk;
        tk.now_us    = now_us;
        tk.seq_start = seq_b;
        tk.seq_end   = seq_e;
        ticks_to_send.push_back(tk);
        ticks_made++;
    endtask

    // register write while the block is idle; mirror follows at once
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WARN_LIMIT:     warn_ms = value[LIMIT_W-1:0];
            CFG_SHUTDOWN_LIMIT: shut_ms = value[LIMIT_W-1:0];
            CFG_START_SEQUENCE: mb_last_seq = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // sender holds off until every queued tick has been answered
    task automatic wait_idle();
        while (ticks_to_send.size() != 0 || s_valid || due_words.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // one stretch of mailbox traffic; may_rewind also allows time to step back
    // and new commands without a visible move in between
    task automatic make_episode(input int unsigned span, input bit may_rewind);
        int unsigned       kind;
        int unsigned       ticks;
        logic [SEQ_W-1:0]  nxt;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            // writer moves the sequence, settles it, then goes quiet
            case ($urandom_range(0, 7))
                0:       nxt = '0;
                1:       nxt = gen_seq + 1;
                default: nxt = {$urandom, $urandom};
            endcase
            if (!may_rewind || $urandom_range(0, 3) != 0)
                push_tick(gen_now, nxt, gen_seq);
            gen_now += $urandom_range(0, span);
            push_tick(gen_now, nxt, nxt);
            gen_seq = nxt;
            ticks = $urandom_range(1, 12);
            repeat (ticks) begin
                gen_now += $urandom_range(0, span);
                // now and then the writer has begun but not finished
                push_tick(gen_now, gen_seq,
                          ($urandom_range(0, 5) == 0) ? gen_seq + 1 : gen_seq);
            end
        end else if (kind == 7 || (kind == 9 && !may_rewind)) begin
            gen_now += $urandom_range(0, 3000);
            push_tick(gen_now, {$urandom, $urandom}, {$urandom, $urandom});
        end else if (kind == 8) begin
            gen_now += $urandom_range(0, 3000);
            push_tick(gen_now, gen_seq + 2, gen_seq + 3);
        end else begin
            gen_now -= $urandom_range(1, span);
            push_tick(gen_now, gen_seq, gen_seq);
        end
    endtask

    task automatic run_phase(input int unsigned n, input bit may_rewind);
        int unsigned first;
        int unsigned span;
        first = ticks_made;
        // steps scaled so stalls cross the limit that matters in this phase
        if (may_rewind)
            span = ((int'(shut_ms) + 1) * 1000) / 3 + 1;
        else
            span = ((int'(warn_ms) + 1) * 1000) / 2 + 1;
        while (ticks_made - first < n)
            make_episode(span, may_rewind);
        // closing move so a running stall timer does not leak into the next setting
        gen_now += 1000;
        push_tick(gen_now, gen_seq ^ 64'h2, gen_seq);
        wait_idle();
    endtask

    // warn path under reset limits (200 ms warn, 500 ms shutdown)
    task automatic directed_warn();
        push_tick(64'd0, 64'd0, 64'd0);              // settled zero, nothing taken yet
        push_tick(64'd1000, 64'd7, 64'd8);           // writer busy
        push_tick(64'd2000, 64'd7, 64'd7);           // first command: go running, timer armed
        push_tick(64'd202000, 64'd7, 64'd7);         // exactly at the warn limit: quiet
        push_tick(64'd203000, 64'd7, 64'd8);         // past it, begin unchanged: warn
        push_tick(64'd402000, 64'd7, 64'd7);         // warning already up: quiet
        push_tick(64'd403000, 64'd8, 64'd9);         // begin moves: warn cleared
        push_tick(64'd404000, 64'd8, 64'd8);         // taken, no running request
        push_tick(64'd404500, 64'd0, 64'd9);         // begin leaves 8: timer cleared
        push_tick(64'd405000, 64'd0, 64'd0);         // zero sequence taken: watchdog off
        push_tick(64'd900000, 64'd5, 64'd0);         // long gap with zero last: ignored
        push_tick(64'd901000, ALL_ONES, ALL_ONES);   // taken from zero: go running again
        push_tick(64'd1102000, ALL_ONES, 64'd0);     // 201 ms: warn
        // new command while stalled: timer keeps its old start
        push_tick(64'd1102500, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        push_tick(64'd1103000, 64'h1234, 64'h1235);  // moving: clears
        push_tick(ALL_ONES, 64'h1234, 64'h1234);     // taken, armed at the top of time
        push_tick(64'd999, 64'h1234, 64'h1234);      // clock wraps: 1 ms, quiet
        push_tick(64'd1000, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5556);
        wait_idle();
    endtask

    // fault path with shutdown below warn (warn 5 ms, shutdown 2 ms)
    task automatic directed_fault();
        logic [SEQ_W-1:0]  seq_a;
        logic [TIME_W-1:0] t0;
        seq_a = 64'hA5A5_A5A5_5A5A_5A5A;
        t0    = gen_now + 1000;
        push_tick(gen_now, seq_a, gen_seq);          // moving
        push_tick(t0, seq_a, seq_a);                 // taken, timer armed
        push_tick(t0 + 2999, seq_a, seq_a);          // 2 ms, not beyond shutdown
        push_tick(t0 + 6000, seq_a, seq_a);          // past both limits: shutdown wins
        push_tick(t0 + 9000, seq_a, seq_a + 1);      // latched: quiet
        push_tick(t0 + 10000, seq_a + 1, seq_a + 2); // moving: latch cleared, fault stays
        push_tick(t0 + 11000, seq_a + 1, seq_a + 1); // taken, timer armed
        push_tick(t0 + 10999, seq_a + 1, seq_a + 1); // time steps back: huge stall, fault again
        gen_now = t0 + 11000;
        gen_seq = seq_a + 1;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin : run_flow
        logic [CFG_DATA_W-1:0] pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_warn();

        // warn-only phases: shutdown held at its maximum, stalls kept well short of it
        gen_now = {$urandom, $urandom};
        write_reg(CFG_WARN_LIMIT, 64'd0);
        write_reg(CFG_SHUTDOWN_LIMIT, 64'd65535);
        write_reg(CFG_START_SEQUENCE, 64'd0);
        gen_seq = '0;
        run_phase(100, 1'b0);

        pick = {$urandom, $urandom};
        write_reg(CFG_WARN_LIMIT, CFG_DATA_W'($urandom_range(1, 3000)));
        write_reg(CFG_START_SEQUENCE, pick);
        gen_seq = pick;
        run_phase(100, 1'b0);

        write_reg(CFG_WARN_LIMIT, 64'd1);
        write_reg(CFG_START_SEQUENCE, ALL_ONES);
        gen_seq = ALL_ONES;
        run_phase(100, 1'b0);

        // from here on severity sits at fault for good
        write_reg(CFG_WARN_LIMIT, 64'd5);
        write_reg(CFG_SHUTDOWN_LIMIT, 64'd2);
        directed_fault();

        write_reg(CFG_WARN_LIMIT, CFG_DATA_W'(WARN_LIMIT_RST));
        write_reg(CFG_SHUTDOWN_LIMIT, CFG_DATA_W'(SHUTDOWN_LIMIT_RST));
        run_phase(145, 1'b1);

        write_reg(CFG_WARN_LIMIT, 64'd0);
        write_reg(CFG_SHUTDOWN_LIMIT, 64'd0);
        run_phase(145, 1'b1);

        write_reg(CFG_WARN_LIMIT, 64'd65535);
        write_reg(CFG_SHUTDOWN_LIMIT, 64'd65535);
        write_reg(CFG_START_SEQUENCE, 64'd0);
        gen_seq = '0;
        run_phase(145, 1'b1);

        // last stretch at full rate on both sides
        calm = 1'b1;
        write_reg(CFG_WARN_LIMIT, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_SHUTDOWN_LIMIT, CFG_DATA_W'($urandom_range(0, 2000)));
        run_phase(145, 1'b1);

        // catch any stray word after the last one due
        repeat (6) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
